// ===== rtl/polar_pose_controller_defines.svh =====
// Assertion macros for the polar pose controller checker.
// No dependencies; included by the checker file only.
`ifndef POLAR_POSE_CONTROLLER_DEFINES_SVH
`define POLAR_POSE_CONTROLLER_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted
`define PPC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

// Clocked assertion that also holds during reset
`define PPC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");

`endif

// ===== rtl/ppc_pkg.sv =====
// Shared types, constants and helper functions for the polar pose controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package ppc_pkg;

  // CORDIC depth, valid from 8 to 24
  localparam int CordicStages = 16;
  localparam int StageIdxW    = 5;

  // datapath widths
  localparam int DiffW     = 33;   // goal minus pose
  localparam int MagW      = 32;   // |dx| | |dy|
  localparam int ShamtW    = 5;    // normalizing shift, 0..31
  localparam int NormSteps = 5;    // binary shift search 16, 8, 4, 2, 1
  localparam int CordicW   = 36;   // x/y through the cells
  localparam int AngW      = 32;   // Q.28 angle accumulator
  localparam int WrapW     = 19;   // Q3.13 angles with headroom
  localparam int RhoW      = 34;   // unsigned distance, Q18.16
  localparam int MulSplit  = 18;   // low part of x for the 1/K multiply
  localparam int InvW      = 30;
  localparam int ProdW     = 64;

  localparam logic signed [WrapW-1:0] PiQ13     = 19'sd25736;
  localparam logic signed [WrapW-1:0] TwoPiQ13  = 19'sd51472;
  localparam logic signed [AngW-1:0]  PiHalfQ28 = 32'sd421657428;
  localparam logic [InvW-1:0]         InvGainQ30 = 30'd652032874;

  localparam logic [31:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [31:0] SatMin = 32'h8000_0000;

  // configuration register indexes
  localparam logic [2:0] RegGainRho   = 3'd0;
  localparam logic [2:0] RegGainAlpha = 3'd1;
  localparam logic [2:0] RegGainBeta  = 3'd2;
  localparam logic [2:0] RegGoalX     = 3'd3;
  localparam logic [2:0] RegGoalY     = 3'd4;
  localparam logic [2:0] RegGoalHead  = 3'd5;
  localparam logic [2:0] RegPosTol    = 3'd6;
  localparam logic [2:0] RegHeadTol   = 3'd7;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] velocity_cmd;
    logic signed [31:0] steering_cmd;
    logic               at_target;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] gain_rho;
    logic signed [15:0] gain_alpha;
    logic signed [15:0] gain_beta;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_heading;
    logic [30:0]        position_tolerance;
    logic [15:0]        heading_tolerance;
  } cfg_t;

  // per-pose side information carried down the pipe
  typedef struct packed {
    logic               close;
    logic               zero;
    logic [ShamtW-1:0]  shamt;
    logic signed [15:0] heading;
  } side_t;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [AngW-1:0]    z;
    side_t                     side;
  } vec_t;

  // arctangent of 2^-i in Q.28 radians
  function automatic logic signed [AngW-1:0] atan_q28(input logic [StageIdxW-1:0] idx);
    logic signed [AngW-1:0] r;
    case (idx)
      5'd0:    r = 32'sd210828714;
      5'd1:    r = 32'sd124459457;
      5'd2:    r = 32'sd65760959;
      5'd3:    r = 32'sd33381290;
      5'd4:    r = 32'sd16755422;
      5'd5:    r = 32'sd8385879;
      5'd6:    r = 32'sd4193963;
      5'd7:    r = 32'sd2097109;
      5'd8:    r = 32'sd1048571;
      5'd9:    r = 32'sd524287;
      5'd10:   r = 32'sd262144;
      5'd11:   r = 32'sd131072;
      5'd12:   r = 32'sd65536;
      5'd13:   r = 32'sd32768;
      5'd14:   r = 32'sd16384;
      5'd15:   r = 32'sd8192;
      5'd16:   r = 32'sd4096;
      5'd17:   r = 32'sd2048;
      5'd18:   r = 32'sd1024;
      5'd19:   r = 32'sd512;
      5'd20:   r = 32'sd256;
      5'd21:   r = 32'sd128;
      5'd22:   r = 32'sd64;
      5'd23:   r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

  // single wrap by 2*pi into [-pi, pi)
  function automatic logic signed [WrapW-1:0] wrap_q13(input logic signed [WrapW-1:0] v);
    logic signed [WrapW-1:0] r;
    if (v >= PiQ13) begin
      r = v - TwoPiQ13;
    end else if (v < -PiQ13) begin
      r = v + TwoPiQ13;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ppc_front.sv =====
// Front end: pose error, closeness test, normalizing shift search and
// quadrant pre-rotation. Depends on ppc_pkg.
`default_nettype none

module ppc_front import ppc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  pose_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output vec_t  out_o
);

  localparam int NumStg = NormSteps + 2;
  localparam int RotStg = NormSteps + 1;

  logic [NumStg-1:0] valid_q;
  logic [NumStg-1:0] stg_ready;

  logic signed [DiffW-1:0] dx_q  [NormSteps+1];
  logic signed [DiffW-1:0] dy_q  [NormSteps+1];
  logic [MagW-1:0]         mag_q [NormSteps+1];
  side_t                   side_q[NormSteps+1];
  vec_t                    out_q;

  // a stage takes a beat when empty or when its successor moves
  for (genvar k = 0; k < NumStg - 1; k++) begin : g_rdy
    assign stg_ready[k] = !valid_q[k] || stg_ready[k+1];
  end
  assign stg_ready[NumStg-1] = !valid_q[NumStg-1] || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stg_ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (stg_ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // stage 0: differences, magnitudes, closeness
  logic signed [DiffW-1:0] dx, dy;
  logic [DiffW-1:0]        adx, ady;
  logic signed [WrapW-1:0] herr;
  logic [WrapW-1:0]        aherr;
  logic                    close;

  always_comb begin
    dx = $signed({cfg_i.goal_x[31], cfg_i.goal_x}) - $signed({in_i.pose_x[31], in_i.pose_x});
    dy = $signed({cfg_i.goal_y[31], cfg_i.goal_y}) - $signed({in_i.pose_y[31], in_i.pose_y});
    adx = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    ady = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
    herr = wrap_q13($signed({{(WrapW-16){in_i.pose_heading[15]}}, in_i.pose_heading})
                  - $signed({{(WrapW-16){cfg_i.goal_heading[15]}}, cfg_i.goal_heading}));
    aherr = herr[WrapW-1] ? WrapW'(-herr) : WrapW'(herr);
    close = (adx <= {2'b00, cfg_i.position_tolerance})
         && (ady <= {2'b00, cfg_i.position_tolerance})
         && (aherr <= {{(WrapW-16){1'b0}}, cfg_i.heading_tolerance});
  end

  always_ff @(posedge clk_i) begin
    if (stg_ready[0] && in_valid_i) begin
      dx_q[0]           <= dx;
      dy_q[0]           <= dy;
      mag_q[0]          <= adx[MagW-1:0] | ady[MagW-1:0];
      side_q[0].close   <= close;
      side_q[0].zero    <= (adx == '0) && (ady == '0);
      side_q[0].shamt   <= '0;
      side_q[0].heading <= in_i.pose_heading;
    end
  end

  // shift search: each step shifts by 16, 8, 4, 2, 1 while the top bits are clear
  for (genvar k = 1; k <= NormSteps; k++) begin : g_norm
    localparam int Amt = 1 << (NormSteps - k);
    logic fits;
    assign fits = (mag_q[k-1] >> (MagW - Amt)) == '0;

    always_ff @(posedge clk_i) begin
      if (stg_ready[k] && valid_q[k-1]) begin
        side_q[k].close   <= side_q[k-1].close;
        side_q[k].zero    <= side_q[k-1].zero;
        side_q[k].heading <= side_q[k-1].heading;
        if (fits) begin
          mag_q[k]        <= mag_q[k-1] << Amt;
          dx_q[k]         <= dx_q[k-1] <<< Amt;
          dy_q[k]         <= dy_q[k-1] <<< Amt;
          side_q[k].shamt <= side_q[k-1].shamt + ShamtW'(Amt);
        end else begin
          mag_q[k]        <= mag_q[k-1];
          dx_q[k]         <= dx_q[k-1];
          dy_q[k]         <= dy_q[k-1];
          side_q[k].shamt <= side_q[k-1].shamt;
        end
      end
    end
  end

  // pre-rotation by +-pi/2 into the right half plane
  logic signed [CordicW-1:0] nx, ny;
  vec_t                      rot;

  always_comb begin
    nx = $signed({{(CordicW-DiffW){dx_q[NormSteps][DiffW-1]}}, dx_q[NormSteps]});
    ny = $signed({{(CordicW-DiffW){dy_q[NormSteps][DiffW-1]}}, dy_q[NormSteps]});
    rot.side = side_q[NormSteps];
    if (nx < 0) begin
      if (ny >= 0) begin
        rot.x = ny;
        rot.y = -nx;
        rot.z = PiHalfQ28;
      end else begin
        rot.x = -ny;
        rot.y = nx;
        rot.z = -PiHalfQ28;
      end
    end else begin
      rot.x = nx;
      rot.y = ny;
      rot.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_ready[RotStg] && valid_q[RotStg-1]) begin
      out_q <= rot;
    end
  end

  assign in_ready_o  = stg_ready[0];
  assign out_valid_o = valid_q[RotStg];
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== rtl/ppc_cordic_cell.sv =====
// One CORDIC vectoring cell: a shift-add micro-rotation and an angle update.
// Depends on ppc_pkg (vec_t, atan table).
`default_nettype none

module ppc_cordic_cell import ppc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [StageIdxW-1:0] idx_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vec_t                 in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output vec_t                 out_o
);

  logic valid_q;
  vec_t data_q, data_d;

  logic signed [CordicW-1:0] xs, ys;
  logic signed [AngW-1:0]    ang;

  assign in_ready_o = !valid_q || out_ready_i;

  // rotate toward the x axis, sign of y picks the direction
  always_comb begin
    xs  = in_i.x >>> idx_i;
    ys  = in_i.y >>> idx_i;
    ang = atan_q28(idx_i);
    data_d.side = in_i.side;
    if (in_i.y < 0) begin
      data_d.x = in_i.x - ys;
      data_d.y = in_i.y + xs;
      data_d.z = in_i.z - ang;
    end else begin
      data_d.x = in_i.x + ys;
      data_d.y = in_i.y - xs;
      data_d.z = in_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

// ===== rtl/ppc_back.sv =====
// Back end: gain correction of rho, bearing to alpha/beta, gain products,
// rounding, saturation and the at-target gate. Depends on ppc_pkg.
`default_nettype none

module ppc_back import ppc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  vec_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_o
);

  localparam int NumStg = 5;
  localparam int HiW    = CordicW - MulSplit;
  localparam int PloW   = MulSplit + InvW;
  localparam int PhiW   = HiW + InvW;
  localparam int BearW  = AngW - 15;
  localparam int PaW    = 16 + WrapW;
  localparam int SsW    = PaW + 1;
  localparam int VpW    = RhoW + 1 + 16;
  localparam int RshW   = ShamtW + 1;

  logic [NumStg-1:0] valid_q;
  logic [NumStg-1:0] stg_ready;

  for (genvar k = 0; k < NumStg - 1; k++) begin : g_rdy
    assign stg_ready[k] = !valid_q[k] || stg_ready[k+1];
  end
  assign stg_ready[NumStg-1] = !valid_q[NumStg-1] || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stg_ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (stg_ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // stage 1: split 1/K multiply, bearing rounding, alpha
  logic [CordicW-1:0]      xu;
  logic [PloW-1:0]         plo_d, plo_q;
  logic [PhiW-1:0]         phi_d, phi_q;
  logic signed [AngW-1:0]  bsum;
  logic signed [BearW-1:0] bearing;
  logic signed [WrapW-1:0] ph1, alpha1_d, alpha1_q;
  side_t                   side1_q;

  always_comb begin
    xu      = in_i.x;
    plo_d   = PloW'(xu[MulSplit-1:0]) * PloW'(InvGainQ30);
    phi_d   = PhiW'(xu[CordicW-1:MulSplit]) * PhiW'(InvGainQ30);
    bsum    = in_i.z + AngW'(16384);
    bearing = in_i.side.zero ? '0 : $signed(bsum[AngW-1:15]);
    ph1     = $signed({{(WrapW-16){in_i.side.heading[15]}}, in_i.side.heading});
    alpha1_d = wrap_q13($signed({{(WrapW-BearW){bearing[BearW-1]}}, bearing}) - ph1);
  end

  always_ff @(posedge clk_i) begin
    if (stg_ready[0] && in_valid_i) begin
      plo_q    <= plo_d;
      phi_q    <= phi_d;
      alpha1_q <= alpha1_d;
      side1_q  <= in_i.side;
    end
  end

  // stage 2: product sum with rounding bit, beta
  logic [RshW-1:0]         rnd_sh;
  logic [ProdW-1:0]        prod_d, prod_q;
  logic signed [WrapW-1:0] ph2, beta2_d, beta2_q, alpha2_q;
  side_t                   side2_q;

  always_comb begin
    rnd_sh  = {1'b0, side1_q.shamt} + RshW'(29);
    prod_d  = (ProdW'(phi_q) << MulSplit) + ProdW'(plo_q) + (ProdW'(1) << rnd_sh);
    ph2     = $signed({{(WrapW-16){side1_q.heading[15]}}, side1_q.heading});
    beta2_d = wrap_q13(-alpha1_q - ph2);
  end

  always_ff @(posedge clk_i) begin
    if (stg_ready[1] && valid_q[0]) begin
      prod_q   <= prod_d;
      alpha2_q <= alpha1_q;
      beta2_q  <= beta2_d;
      side2_q  <= side1_q;
    end
  end

  // stage 3: shift rho back, steering gain products
  logic [RshW-1:0]       rsh;
  logic [ProdW-1:0]      rho_full;
  logic [RhoW-1:0]       rho_d, rho_q;
  logic signed [PaW-1:0] pa_d, pa_q, pb_d, pb_q;
  logic                  close3_q;

  always_comb begin
    rsh      = {1'b0, side2_q.shamt} + RshW'(30);
    rho_full = prod_q >> rsh;
    rho_d    = side2_q.zero ? '0 : rho_full[RhoW-1:0];
    pa_d     = PaW'(cfg_i.gain_alpha) * PaW'(alpha2_q);
    pb_d     = PaW'(cfg_i.gain_beta) * PaW'(beta2_q);
  end

  always_ff @(posedge clk_i) begin
    if (stg_ready[2] && valid_q[1]) begin
      rho_q    <= rho_d;
      pa_q     <= pa_d;
      pb_q     <= pb_d;
      close3_q <= side2_q.close;
    end
  end

  // stage 4: velocity product, steering round and saturate
  logic signed [VpW-1:0] vp_d, vp_q;
  logic signed [SsW-1:0] ss, ssh;
  logic [SsW-32:0]       s_hi;
  logic [31:0]           steer_d, steer_q;
  logic                  close4_q;

  always_comb begin
    vp_d    = VpW'($signed({1'b0, rho_q})) * VpW'(cfg_i.gain_rho);
    ss      = SsW'(pa_q) + SsW'(pb_q) + SsW'(16);
    ssh     = ss >>> 5;
    s_hi    = ssh[SsW-1:31];
    steer_d = ((&s_hi) || !(|s_hi)) ? ssh[31:0] : (ssh[SsW-1] ? SatMin : SatMax);
  end

  always_ff @(posedge clk_i) begin
    if (stg_ready[3] && valid_q[2]) begin
      vp_q     <= vp_d;
      steer_q  <= steer_d;
      close4_q <= close3_q;
    end
  end

  // stage 5: velocity round and saturate, target gate, output register
  logic signed [VpW-1:0] vr;
  logic [VpW-32:0]       v_hi;
  logic [31:0]           vel;
  cmd_t                  out_q;

  always_comb begin
    vr   = (vp_q + VpW'(128)) >>> 8;
    v_hi = vr[VpW-1:31];
    vel  = ((&v_hi) || !(|v_hi)) ? vr[31:0] : (vr[VpW-1] ? SatMin : SatMax);
  end

  always_ff @(posedge clk_i) begin
    if (stg_ready[4] && valid_q[3]) begin
      out_q.velocity_cmd <= close4_q ? '0 : $signed(vel);
      out_q.steering_cmd <= close4_q ? '0 : $signed(steer_q);
      out_q.at_target    <= close4_q;
    end
  end

  assign in_ready_o  = stg_ready[0];
  assign out_valid_o = valid_q[NumStg-1];
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== rtl/polar_pose_controller.sv =====
// Polar pose controller: pose in, velocity and steering commands out.
// Uses ppc_pkg, ppc_front, ppc_cordic_cell and ppc_back.
//
// Usage:
//   pose channel (pose_valid_i / pose_ready_o / pose_i) carries one measured
//   pose per beat; cmd channel (cmd_valid_o / cmd_ready_i / cmd_o) returns one
//   command per pose, in order.
//   Configuration: write gains, goal and tolerances through cfg_we_i,
//   cfg_index_i and cfg_wdata_i while no pose is in flight.
//   Throughput: one pose per cycle, sustained while cmd_ready_i stays high.
//   Pipeline: 7 front stages (error, five shift search steps, pre-rotation),
//   the chain of vectoring cells, 5 back stages for the split 1/K multiply,
//   gain products and saturation.
//   Reset: all stage valid bits clear, configuration registers take their defaults
//   (gains 3.0 / 8.0 / -3.0, goal at origin, tolerances 1.0 m and 0.8 rad).
//   Receiver stall: the command is held in the output register; earlier
//   stages keep filling until every stage holds a pose, then pose_ready_o drops.
`default_nettype none

module polar_pose_controller import ppc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        pose_valid_i,
  output logic        pose_ready_o,
  input  pose_t       pose_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  cfg_t cfg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_rho           <= 16'sd768;
      cfg_q.gain_alpha         <= 16'sd2048;
      cfg_q.gain_beta          <= -16'sd768;
      cfg_q.goal_x             <= '0;
      cfg_q.goal_y             <= '0;
      cfg_q.goal_heading       <= '0;
      cfg_q.position_tolerance <= 31'd65536;
      cfg_q.heading_tolerance  <= 16'd6554;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegGainRho:   cfg_q.gain_rho           <= $signed(cfg_wdata_i[15:0]);
        RegGainAlpha: cfg_q.gain_alpha         <= $signed(cfg_wdata_i[15:0]);
        RegGainBeta:  cfg_q.gain_beta          <= $signed(cfg_wdata_i[15:0]);
        RegGoalX:     cfg_q.goal_x             <= $signed(cfg_wdata_i);
        RegGoalY:     cfg_q.goal_y             <= $signed(cfg_wdata_i);
        RegGoalHead:  cfg_q.goal_heading       <= $signed(cfg_wdata_i[15:0]);
        RegPosTol:    cfg_q.position_tolerance <= cfg_wdata_i[30:0];
        RegHeadTol:   cfg_q.heading_tolerance  <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  vec_t                  cell_data [CordicStages+1];
  logic [CordicStages:0] cell_valid;
  logic [CordicStages:0] cell_ready;

  ppc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pose_valid_i),
    .in_ready_o  (pose_ready_o),
    .in_i        (pose_i),
    .out_valid_o (cell_valid[0]),
    .out_ready_i (cell_ready[0]),
    .out_o       (cell_data[0])
  );

  // chain of vectoring cells
  for (genvar k = 0; k < CordicStages; k++) begin : g_cell
    ppc_cordic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (StageIdxW'(k)),
      .in_valid_i  (cell_valid[k]),
      .in_ready_o  (cell_ready[k]),
      .in_i        (cell_data[k]),
      .out_valid_o (cell_valid[k+1]),
      .out_ready_i (cell_ready[k+1]),
      .out_o       (cell_data[k+1])
    );
  end

  ppc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (cell_valid[CordicStages]),
    .in_ready_o  (cell_ready[CordicStages]),
    .in_i        (cell_data[CordicStages]),
    .out_valid_o (cmd_valid_o),
    .out_ready_i (cmd_ready_i),
    .out_o       (cmd_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ppc_checker.sv =====
// Port-level checker for the polar pose controller, bound to the top level.
// Depends on ppc_pkg and polar_pose_controller_defines.svh.
`default_nettype none
`include "polar_pose_controller_defines.svh"

module ppc_checker import ppc_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  pose_valid_i,
  input logic  pose_ready_i,
  input pose_t pose_i,
  input logic  cmd_valid_i,
  input logic  cmd_ready_i,
  input cmd_t  cmd_i
);

  // a reset cycle leaves no command beat behind it
  `PPC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !cmd_valid_i)

  // a stalled pose beat stays put
  `PPC_ASSERT(a_pose_hold, clk_i, rst_ni,
              pose_valid_i && !pose_ready_i |=> pose_valid_i && $stable(pose_i))

  // a stalled command stays put
  `PPC_ASSERT(a_cmd_hold, clk_i, rst_ni,
              cmd_valid_i && !cmd_ready_i |=> cmd_valid_i && $stable(cmd_i))

  // at target both commands are zero
  `PPC_ASSERT(a_target_zero, clk_i, rst_ni,
              cmd_valid_i && cmd_i.at_target |->
              cmd_i.velocity_cmd == 0 && cmd_i.steering_cmd == 0)

  // empty output stage means the pipe can take a pose
  `PPC_ASSERT(a_empty_ready, clk_i, rst_ni, !cmd_valid_i |-> pose_ready_i)

endmodule

bind polar_pose_controller ppc_checker u_ppc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pose_valid_i (pose_valid_i),
  .pose_ready_i (pose_ready_o),
  .pose_i       (pose_i),
  .cmd_valid_i  (cmd_valid_o),
  .cmd_ready_i  (cmd_ready_i),
  .cmd_i        (cmd_o)
);

`default_nettype wire
